// ===== rtl/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, widths and micro-op codes of the look-ahead target block
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 68;
    localparam int ACC_W      = 68;
    localparam int T_FRAC     = 16;
    localparam int T_W        = 17;
    localparam int ROOT_W     = 34;
    localparam int DIV_W      = 64;
    localparam int SCALE_W    = 31;
    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_W      = 6;
    localparam int TG_W       = 36;

    localparam logic [1:0] REG_PATH_LENGTH = 2'd0;
    localparam logic [1:0] REG_LOOK_AHEAD  = 2'd1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic [4:0]                t_op;

    localparam t_op OP_NONE = 5'd0;
    localparam t_op OP_CAPT = 5'd1;
    localparam t_op OP_LD_A = 5'd2;
    localparam t_op OP_LD_B = 5'd3;
    localparam t_op OP_DOT  = 5'd4;
    localparam t_op OP_LEN  = 5'd5;
    localparam t_op OP_TDEC = 5'd6;
    localparam t_op OP_TDIV = 5'd7;
    localparam t_op OP_PROJ = 5'd8;
    localparam t_op OP_DIST = 5'd9;
    localparam t_op OP_CMP  = 5'd10;
    localparam t_op OP_FIN  = 5'd11;
    localparam t_op OP_SQ   = 5'd12;
    localparam t_op OP_SQI  = 5'd13;
    localparam t_op OP_SQRT = 5'd14;
    localparam t_op OP_BR   = 5'd15;
    localparam t_op OP_LDK  = 5'd16;
    localparam t_op OP_FLEN = 5'd17;
    localparam t_op OP_SCI  = 5'd18;
    localparam t_op OP_DIV  = 5'd19;
    localparam t_op OP_TG   = 5'd20;
    localparam t_op OP_ZERO = 5'd21;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;
        logic       first;
        logic       wr;
    } t_cmd;

    typedef struct packed {
        logic t_iter;
        logic closer;
        logic near;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/plt_dp.sv =====
// ----------------------------------------------------------------------------
// plt_dp
// point memory, shared multiplier, divide and square root steps of the block
// ----------------------------------------------------------------------------
`default_nettype none

module plt_dp
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 32,
    localparam int IW = $clog2(MAX_POINTS)
) (
    input  wire logic               i_clk,
    input  wire t_cmd               i_cmd,
    input  wire logic [IW-1:0]      i_rd_addr,
    input  wire logic [IW-1:0]      i_wr_addr,
    input  wire t_coord             i_x,
    input  wire t_coord             i_y,
    input  wire t_coord             i_z,
    input  wire logic [SCALE_W-1:0] i_look_ahead,
    output t_sts                    o_sts,
    output t_coord                  o_tx,
    output t_coord                  o_ty,
    output t_coord                  o_tz
);

    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam longint SAT_HI_L = (longint'(1) <<< (CW - 1)) - longint'(1);
    localparam logic signed [TG_W-1:0] SAT_HI = TG_W'(SAT_HI_L);
    localparam logic signed [TG_W-1:0] SAT_LO = -SAT_HI - TG_W'(1);

    t_coord r_mem_x [MAX_POINTS];
    t_coord r_mem_y [MAX_POINTS];
    t_coord r_mem_z [MAX_POINTS];

    t_coord r_rd [3];
    t_coord r_p [3];
    t_coord r_a [3];
    t_coord r_b [3];
    t_coord r_c [3];
    t_coord r_nr [3];
    t_coord r_nx [3];
    t_coord r_base [3];
    t_coord r_tg [3];
    t_diff  r_e [3];
    t_diff  r_w [3];

    logic signed [ACC_W-1:0] r_dot;
    logic signed [ACC_W-1:0] r_len2;
    logic [ACC_W-1:0]        r_dst;
    logic [ACC_W-1:0]        r_best;
    logic [T_W-1:0]          r_t;
    logic [ACC_W:0]          r_rem;
    logic [ACC_W-1:0]        r_sqv;
    logic [ROOT_W-1:0]       r_root;
    logic [ROOT_W+1:0]       r_srem;
    logic [SCALE_W-1:0]      r_s;
    logic [ROOT_W-1:0]       r_len;
    logic [DIV_W-1:0]        r_dq;
    logic [ROOT_W-1:0]       r_drem;

    logic [1:0]              k;
    t_diff                   diff_cp;
    logic [DIFF_W-1:0]       mag_e;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] proj;
    logic [ACC_W:0]          rem2;
    logic [ACC_W:0]          len2_u;
    logic                    tdiv_ge;
    logic [ROOT_W+3:0]       srem_sh;
    logic [ROOT_W+3:0]       trial;
    logic                    sq_ge;
    logic [ROOT_W:0]         drem_sh;
    logic                    div_ge;
    logic [ROOT_W-1:0]       q;
    logic signed [TG_W-1:0]  qs;
    logic signed [TG_W-1:0]  tgv;
    t_coord                  tg_sat;
    logic                    near;

    assign k       = i_cmd.k;
    assign diff_cp = t_diff'(r_c[k]) - t_diff'(r_p[k]);
    assign mag_e   = r_e[k][DIFF_W-1] ? DIFF_W'(-r_e[k]) : DIFF_W'(r_e[k]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_DOT: begin
                mul_a = MUL_W'(r_e[k]);
                mul_b = MUL_W'(r_w[k]);
            end
            OP_LEN, OP_SQ: begin
                mul_a = MUL_W'(r_e[k]);
                mul_b = MUL_W'(r_e[k]);
            end
            OP_PROJ: begin
                mul_a = MUL_W'(r_e[k]);
                mul_b = $signed({{(MUL_W-T_W){1'b0}}, r_t});
            end
            OP_DIST: begin
                mul_a = MUL_W'(diff_cp);
                mul_b = MUL_W'(diff_cp);
            end
            OP_SCI: begin
                mul_a = $signed({1'b0, mag_e});
                mul_b = $signed({{(MUL_W-SCALE_W){1'b0}}, r_s});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign proj  = PROD_W'(r_a[k]) + (mul_p >>> T_FRAC);

    // projection factor, restoring divide
    assign rem2    = {r_rem[ACC_W-1:0], 1'b0};
    assign len2_u  = {1'b0, $unsigned(r_len2)};
    assign tdiv_ge = rem2 >= len2_u;

    // floor square root, two radicand bits a step
    assign srem_sh = {r_srem, r_sqv[ACC_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    // step scaling, restoring divide
    assign drem_sh = {r_drem, r_dq[DIV_W-1]};
    assign div_ge  = drem_sh >= {1'b0, r_len};

    assign q   = (r_len == '0) ? '0 : r_dq[ROOT_W-1:0];
    assign qs  = $signed({2'b00, q});
    assign tgv = TG_W'(r_base[k]) + (r_e[k][DIFF_W-1] ? -qs : qs);
    assign tg_sat = (tgv > SAT_HI) ? COORD_W'(SAT_HI)
                  : (tgv < SAT_LO) ? COORD_W'(SAT_LO)
                  : COORD_W'(tgv);

    assign near = (r_root != '0) && (ROOT_W'(i_look_ahead) < r_root);

    assign o_sts.t_iter = (r_len2 != '0) && (r_dot > 0) && (r_dot < r_len2);
    assign o_sts.closer = r_dst < r_best;
    assign o_sts.near   = near;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem_x[i_wr_addr] <= i_x;
            r_mem_y[i_wr_addr] <= i_y;
            r_mem_z[i_wr_addr] <= i_z;
        end
        r_rd[0] <= r_mem_x[i_rd_addr];
        r_rd[1] <= r_mem_y[i_rd_addr];
        r_rd[2] <= r_mem_z[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPT: begin
                r_p[0] <= i_x;
                r_p[1] <= i_y;
                r_p[2] <= i_z;
            end
            OP_LD_A: begin
                for (int n = 0; n < 3; n++) r_a[n] <= r_rd[n];
            end
            OP_LD_B: begin
                for (int n = 0; n < 3; n++) begin
                    r_b[n] <= r_rd[n];
                    r_e[n] <= t_diff'(r_rd[n]) - t_diff'(r_a[n]);
                    r_w[n] <= t_diff'(r_p[n]) - t_diff'(r_a[n]);
                end
                r_dot  <= '0;
                r_len2 <= '0;
            end
            OP_DOT: r_dot <= r_dot + mul_p;
            OP_LEN, OP_SQ: r_len2 <= r_len2 + mul_p;
            OP_TDEC: begin
                if ((r_len2 == '0) || (r_dot <= 0)) begin
                    r_t <= '0;
                end else if (r_dot >= r_len2) begin
                    r_t <= T_W'(1) << T_FRAC;
                end else begin
                    r_t <= '0;
                end
                r_rem <= {1'b0, $unsigned(r_dot)};
            end
            OP_TDIV: begin
                r_rem <= tdiv_ge ? (rem2 - len2_u) : rem2;
                r_t   <= {r_t[T_W-2:0], tdiv_ge};
            end
            OP_PROJ: begin
                r_c[k] <= COORD_W'(proj);
                r_dst  <= '0;
            end
            OP_DIST: r_dst <= r_dst + ACC_W'($unsigned(mul_p));
            OP_CMP: begin
                if (i_cmd.first || o_sts.closer) begin
                    r_best <= r_dst;
                    for (int n = 0; n < 3; n++) begin
                        r_nr[n] <= r_c[n];
                        r_nx[n] <= r_b[n];
                    end
                end
            end
            OP_FIN: begin
                for (int n = 0; n < 3; n++) r_e[n] <= t_diff'(r_nx[n]) - t_diff'(r_nr[n]);
                r_len2 <= '0;
            end
            OP_SQI: begin
                r_sqv  <= $unsigned(r_len2);
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQRT: begin
                r_srem <= (ROOT_W+2)'(sq_ge ? (srem_sh - trial) : srem_sh);
                r_root <= {r_root[ROOT_W-2:0], sq_ge};
                r_sqv  <= {r_sqv[ACC_W-3:0], 2'b00};
            end
            OP_BR: begin
                if (near) begin
                    for (int n = 0; n < 3; n++) r_base[n] <= r_nr[n];
                    r_s   <= i_look_ahead;
                    r_len <= r_root;
                end else begin
                    for (int n = 0; n < 3; n++) r_base[n] <= r_nx[n];
                    r_s <= (r_root == '0) ? '0
                         : SCALE_W'(ROOT_W'(i_look_ahead) - r_root);
                end
            end
            OP_LDK: begin
                for (int n = 0; n < 3; n++) r_e[n] <= t_diff'(r_rd[n]) - t_diff'(r_nx[n]);
                r_len2 <= '0;
            end
            OP_FLEN: r_len <= r_root;
            OP_SCI: begin
                r_dq   <= DIV_W'($unsigned(mul_p));
                r_drem <= '0;
            end
            OP_DIV: begin
                r_drem <= ROOT_W'(div_ge ? (drem_sh - {1'b0, r_len}) : drem_sh);
                r_dq   <= {r_dq[DIV_W-2:0], div_ge};
            end
            OP_TG: r_tg[k] <= tg_sat;
            OP_ZERO: begin
                for (int n = 0; n < 3; n++) r_tg[n] <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_tx = r_tg[0];
    assign o_ty = r_tg[1];
    assign o_tz = r_tg[2];

endmodule

`default_nettype wire

// ===== rtl/plt_ctrl.sv =====
// ----------------------------------------------------------------------------
// plt_ctrl
// sequencer: point writes, segment walk, square roots and step scaling of one query
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ctrl
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int NW = IW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_kind,
    input  wire logic [5:0]    i_point_index,
    input  wire logic [6:0]    i_path_length,
    input  wire t_sts          i_sts,
    input  wire logic          i_out_busy,
    output logic               o_out_load,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_rd_addr,
    output logic [IW-1:0]      o_end
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ZERO = 5'd1;
    localparam logic [4:0] S_RDA  = 5'd2;
    localparam logic [4:0] S_RDB  = 5'd3;
    localparam logic [4:0] S_LDB  = 5'd4;
    localparam logic [4:0] S_DOT  = 5'd5;
    localparam logic [4:0] S_LEN  = 5'd6;
    localparam logic [4:0] S_TDEC = 5'd7;
    localparam logic [4:0] S_TDIV = 5'd8;
    localparam logic [4:0] S_PROJ = 5'd9;
    localparam logic [4:0] S_DIST = 5'd10;
    localparam logic [4:0] S_CMP  = 5'd11;
    localparam logic [4:0] S_FIN  = 5'd12;
    localparam logic [4:0] S_SQ   = 5'd13;
    localparam logic [4:0] S_SQI  = 5'd14;
    localparam logic [4:0] S_SQRT = 5'd15;
    localparam logic [4:0] S_BR   = 5'd16;
    localparam logic [4:0] S_LDK  = 5'd17;
    localparam logic [4:0] S_FLEN = 5'd18;
    localparam logic [4:0] S_SCI  = 5'd19;
    localparam logic [4:0] S_DIV  = 5'd20;
    localparam logic [4:0] S_TG   = 5'd21;
    localparam logic [4:0] S_DONE = 5'd22;

    logic [4:0]       r_state, n_state;
    logic [IW-1:0]    r_i, n_i;
    logic [NW-1:0]    r_n, n_n;
    logic [IW-1:0]    r_end, n_end;
    logic [1:0]       r_k, n_k;
    logic [CNT_W-1:0] r_sub, n_sub;
    logic             r_phase, n_phase;

    logic             slot_ok;
    logic [NW-1:0]    n_clamp;
    logic [NW-1:0]    i_inc;
    logic             last;
    logic [IW-1:0]    j;
    logic [NW-1:0]    e_inc;
    logic [IW-1:0]    kidx;
    logic             first;

    assign slot_ok = 32'(i_point_index) < 32'(MAX_POINTS);
    assign n_clamp = (32'(i_path_length) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                            : NW'(i_path_length);
    assign i_inc = {1'b0, r_i} + NW'(1);
    assign last  = i_inc == r_n;
    assign j     = last ? '0 : i_inc[IW-1:0];
    assign e_inc = {1'b0, r_end} + NW'(1);
    assign kidx  = (e_inc >= r_n) ? '0 : e_inc[IW-1:0];
    assign first = r_i == '0;

    assign o_in_stall = r_state != S_IDLE;
    assign o_end      = r_end;

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_n        = r_n;
        n_end      = r_end;
        n_k        = r_k;
        n_sub      = r_sub;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_cmd.k    = r_k;
        o_rd_addr  = r_i;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.op = OP_CAPT;
                        n_n      = n_clamp;
                        n_i      = '0;
                        n_state  = (n_clamp == '0) ? S_ZERO : S_RDA;
                    end else begin
                        o_cmd.wr = slot_ok;
                    end
                end
            end
            S_ZERO: begin
                o_cmd.op = OP_ZERO;
                n_end    = '0;
                n_state  = S_DONE;
            end
            S_RDA: begin
                o_rd_addr = r_i;
                n_state   = S_RDB;
            end
            S_RDB: begin
                o_cmd.op  = OP_LD_A;
                o_rd_addr = j;
                n_state   = S_LDB;
            end
            S_LDB: begin
                o_cmd.op = OP_LD_B;
                n_k      = '0;
                n_state  = S_DOT;
            end
            S_DOT: begin
                o_cmd.op = OP_DOT;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_LEN;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_LEN: begin
                o_cmd.op = OP_LEN;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_TDEC;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_TDEC: begin
                o_cmd.op = OP_TDEC;
                n_sub    = '0;
                n_state  = i_sts.t_iter ? S_TDIV : S_PROJ;
            end
            S_TDIV: begin
                o_cmd.op = OP_TDIV;
                if (r_sub == CNT_W'(T_FRAC - 1)) begin
                    n_state = S_PROJ;
                end else begin
                    n_sub = r_sub + CNT_W'(1);
                end
            end
            S_PROJ: begin
                o_cmd.op = OP_PROJ;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_DIST;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_DIST: begin
                o_cmd.op = OP_DIST;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_CMP;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_CMP: begin
                o_cmd.op    = OP_CMP;
                o_cmd.first = first;
                if (first || i_sts.closer) begin
                    n_end = j;
                end
                if (last) begin
                    n_state = S_FIN;
                end else begin
                    n_i     = j;
                    n_state = S_RDA;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                n_phase  = 1'b0;
                n_k      = '0;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_SQI;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_SQI: begin
                o_cmd.op = OP_SQI;
                n_sub    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_sub == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = r_phase ? S_FLEN : S_BR;
                end else begin
                    n_sub = r_sub + CNT_W'(1);
                end
            end
            S_BR: begin
                o_cmd.op  = OP_BR;
                o_rd_addr = kidx;
                n_k       = '0;
                n_state   = i_sts.near ? S_SCI : S_LDK;
            end
            S_LDK: begin
                o_cmd.op = OP_LDK;
                n_phase  = 1'b1;
                n_k      = '0;
                n_state  = S_SQ;
            end
            S_FLEN: begin
                o_cmd.op = OP_FLEN;
                n_k      = '0;
                n_state  = S_SCI;
            end
            S_SCI: begin
                o_cmd.op = OP_SCI;
                n_sub    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_sub == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_TG;
                end else begin
                    n_sub = r_sub + CNT_W'(1);
                end
            end
            S_TG: begin
                o_cmd.op = OP_TG;
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SCI;
                end
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_n     <= '0;
            r_end   <= '0;
            r_k     <= '0;
            r_sub   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_n     <= n_n;
            r_end   <= n_end;
            r_k     <= n_k;
            r_sub   <= n_sub;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/path_lookahead_target_top.sv =====
// timing: a query on an empty path only zeroes the target; else its time grows
// with the number of segments, less for each segment whose projection is
// clamped, and is set by the shared multiplier and the bit-serial divide and
// square root steps; one query runs at a time, next item taken when done
// throughput: loads one per cycle while no query is in progress
// reset: synchronous active low, clears control, config and output valid only
// ----------------------------------------------------------------------------
// path_lookahead_target_top
// look-ahead target on a closed 3d polyline held in a point memory
// ----------------------------------------------------------------------------
`default_nettype none

module path_lookahead_target_top
    import plt_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [5:0]  i_point_index,
    input  wire logic signed [31:0] i_x,
    input  wire logic signed [31:0] i_y,
    input  wire logic signed [31:0] i_z,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [31:0] o_target_x,
    output logic signed [31:0] o_target_y,
    output logic signed [31:0] o_target_z,
    output logic [5:0]       o_segment_end
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam int SH = COORD_W - CW;

    logic [6:0]         r_path_length;
    logic [SCALE_W-1:0] r_look_ahead;
    logic               r_out_valid;
    t_coord             r_target_x;
    t_coord             r_target_y;
    t_coord             r_target_z;
    logic [5:0]         r_seg_end;

    t_coord        in_x, in_y, in_z;
    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] seg_end;
    logic          out_load;
    logic          out_busy;
    t_coord        tx, ty, tz;

    assign in_x = (i_x <<< SH) >>> SH;
    assign in_y = (i_y <<< SH) >>> SH;
    assign in_z = (i_z <<< SH) >>> SH;

    assign o_cfg_ready = 1'b1;
    assign out_busy    = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_length <= '0;
            r_look_ahead  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PATH_LENGTH: r_path_length <= i_cfg_data[6:0];
                REG_LOOK_AHEAD:  r_look_ahead  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    plt_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_point_index (i_point_index),
        .i_path_length (r_path_length),
        .i_sts         (sts),
        .i_out_busy    (out_busy),
        .o_out_load    (out_load),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr),
        .o_end         (seg_end)
    );

    plt_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (IW'(i_point_index)),
        .i_x          (in_x),
        .i_y          (in_y),
        .i_z          (in_z),
        .i_look_ahead (r_look_ahead),
        .o_sts        (sts),
        .o_tx         (tx),
        .o_ty         (ty),
        .o_tz         (tz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_target_x <= tx;
            r_target_y <= ty;
            r_target_z <= tz;
            r_seg_end  <= 6'(seg_end);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target_x    = r_target_x;
    assign o_target_y    = r_target_y;
    assign o_target_z    = r_target_z;
    assign o_segment_end = r_seg_end;

endmodule

`default_nettype wire

// ===== rtl/plt_checker.sv =====
// ----------------------------------------------------------------------------
// plt_checker
// port-level checks of the look-ahead target block
// ----------------------------------------------------------------------------
`default_nettype none

module plt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_kind,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind |=> o_in_stall)
        else $error("query item not followed by busy");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_kind |=> !o_in_stall)
        else $error("load item stalled the input");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind path_lookahead_target_top plt_checker u_plt_checker (.*);

`default_nettype wire
